// ===== sv/pocnt_pkg.sv =====
package pocnt_pkg;

  // sizes of the pattern store and the running count
  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned COUNT_BITS  = 32;

  // fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned COOL_W     = 5;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned WORD_BYTES = DATA_W / BYTE_W;
  localparam int unsigned PAT_BYTES  = NUM_WORDS * WORD_BYTES;
  localparam int unsigned PAT_IDX_W  = $clog2(PAT_BYTES);
  localparam int unsigned IDX_W      = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_WORD_0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_WORD_1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_WORD_2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_WORD_3 = 3'd4;

  typedef logic [BYTE_W-1:0] byte_t;

  // control broadcast to every window cell
  typedef struct packed {
    logic load;   // capture compare result
    logic shift;  // move the window by one byte
    logic clear;  // end of text, empty the window
  } cell_ctrl_t;

  // per-byte information handed from the cell row to the tally stage
  typedef struct packed {
    logic             active;
    logic             last;
    logic [LEN_W-1:0] len;
  } item_t;

endpackage

// ===== sv/pocnt_cfg.sv =====
module pocnt_cfg import pocnt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_index_i,
  input  logic [DATA_W-1:0]      cfg_data_i,
  output byte_t                  pat_o [PATTERN_MAX],
  output logic [PATTERN_MAX-1:0] used_o,
  output logic [LEN_W-1:0]       eff_len_o
);

  logic [LEN_W-1:0]       len_q, len_d;
  logic [DATA_W-1:0]      word_q [NUM_WORDS];
  logic [DATA_W-1:0]      word_d [NUM_WORDS];
  byte_t                  pat_q [PATTERN_MAX];
  byte_t                  pat_d [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] used_q, used_d;
  logic [LEN_W-1:0]       eff_q, eff_d;
  byte_t                  pb [PAT_BYTES];
  logic [LEN_W-1:0]       cap;
  logic [PATTERN_MAX-1:0] nz_mask;
  logic [LEN_W-1:0]       sel [PATTERN_MAX];

  always_comb begin
    len_d  = len_q;
    word_d = word_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LENGTH: len_d     = cfg_data_i[LEN_W-1:0];
        REG_WORD_0: word_d[0] = cfg_data_i;
        REG_WORD_1: word_d[1] = cfg_data_i;
        REG_WORD_2: word_d[2] = cfg_data_i;
        REG_WORD_3: word_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  // pattern bytes, then the length cut at the cap and the first zero byte
  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      pb[i] = word_d[i / WORD_BYTES][BYTE_W*(i % WORD_BYTES) +: BYTE_W];
    end
    cap = (len_d > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_d;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      nz_mask[i] = (LEN_W'(i) < cap) && (pb[i] != '0);
    end
    eff_d = LEN_W'(PATTERN_MAX);
    for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
      if (!nz_mask[i]) eff_d = LEN_W'(i);
    end
  end

  // cell k holds the pattern byte that must sit k places back in the window
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      used_d[k] = LEN_W'(k) < eff_d;
      sel[k]    = eff_d - LEN_W'(1) - LEN_W'(k);
      pat_d[k]  = used_d[k] ? pb[sel[k][PAT_IDX_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      eff_q  <= '0;
      used_q <= '0;
      for (int i = 0; i < NUM_WORDS; i++) word_q[i] <= '0;
      for (int k = 0; k < PATTERN_MAX; k++) pat_q[k] <= '0;
    end else begin
      len_q  <= len_d;
      word_q <= word_d;
      eff_q  <= eff_d;
      used_q <= used_d;
      pat_q  <= pat_d;
    end
  end

  assign pat_o     = pat_q;
  assign used_o    = used_q;
  assign eff_len_o = eff_q;

endmodule

// ===== sv/pocnt_cell.sv =====
module pocnt_cell import pocnt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  byte_t      byte_i,
  input  byte_t      pat_i,
  input  logic       used_i,
  output byte_t      byte_o,
  output logic       ok_o
);

  byte_t win_q;
  logic  ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctrl_i.clear) begin
      win_q <= '0;
    end else if (ctrl_i.shift) begin
      win_q <= byte_i;
    end
  end

  // compare against the byte that enters this place
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ok_q <= !used_i || (byte_i == pat_i);
    end
  end

  assign byte_o = win_q;
  assign ok_o   = ok_q;

endmodule

// ===== sv/pocnt_tally.sv =====
module pocnt_tally import pocnt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  item_t                  item_i,
  input  logic [PATTERN_MAX-1:0] ok_i,
  output logic                   fire_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_W-1:0]       occurrence_count_o,
  output logic                   count_saturated_o
);

  logic [COUNT_BITS-1:0] count_q, count_d, count_next;
  logic                  sat_q, sat_d, sat_next;
  logic [COOL_W-1:0]     cool_q, cool_d, cool_next;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_count_q;
  logic                  out_sat_q;
  logic                  fire;
  logic                  hit;

  assign fire = item_valid_i && (!item_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    hit = item_i.active && (item_i.len != '0) && (cool_q == '0) && (&ok_i);
    count_next = (hit && !(&count_q)) ? count_q + COUNT_BITS'(1) : count_q;
    sat_next   = sat_q || (hit && (&count_next));
    if (hit) begin
      cool_next = COOL_W'(item_i.len - LEN_W'(1));
    end else if (item_i.active && (cool_q != '0)) begin
      cool_next = cool_q - COOL_W'(1);
    end else begin
      cool_next = cool_q;
    end
  end

  always_comb begin
    count_d = count_q;
    sat_d   = sat_q;
    cool_d  = cool_q;
    if (fire) begin
      if (item_i.last) begin
        count_d = '0;
        sat_d   = 1'b0;
        cool_d  = '0;
      end else begin
        count_d = count_next;
        sat_d   = sat_next;
        cool_d  = cool_next;
      end
    end
    out_valid_d = (out_valid_q && !out_ready_i) || (fire && item_i.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sat_q       <= 1'b0;
      cool_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sat_q       <= sat_d;
      cool_q      <= cool_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && item_i.last) begin
      out_count_q <= OUT_W'(count_next);
      out_sat_q   <= sat_next;
    end
  end

  assign fire_o             = fire;
  assign out_valid_o        = out_valid_q;
  assign occurrence_count_o = out_count_q;
  assign count_saturated_o  = out_sat_q;

  a_cool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cool_q <= COOL_W'(PATTERN_MAX - 1))
    else $error("cooldown beyond pattern length");

  a_sat_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (&count_q))
    else $error("saturation flag without full count");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_i.last) |=> (count_q == '0) && (cool_q == '0) && !sat_q)
    else $error("per-text state not cleared after last byte");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && item_i.last))
    else $error("result raised without a last byte");

endmodule

// ===== sv/pattern_occurrence_counter_top.sv =====
// counts leftmost, non-overlapping occurrences of a pattern of up to 32 nonzero
// bytes in a text streamed one byte per transfer; the transfer marked last
// returns the saturating count and clears all per-text state. a row of 32
// window cells shifts in each byte before the first zero byte and compares it
// against a pre-aligned copy of the pattern in the cycle of the transfer; the
// compare results are registered and a tally stage applies the cooldown and
// updates the count. one byte is taken every cycle except at the only stall, a
// last byte whose result finds the output register still occupied; the tally
// stage writes the result there. a zero text byte stops counting until the
// end of the text. configuration writes take effect for bytes transferred from
// the following cycle on; no clearing pass is needed after reset
module pattern_occurrence_counter_top import pocnt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  // text byte stream
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic              last_byte_i,
  // count result
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  occurrence_count_o,
  output logic              count_saturated_o
);

  byte_t                  pat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] used;
  logic [LEN_W-1:0]       eff_len;
  byte_t                  win [PATTERN_MAX];
  byte_t                  chain_in [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok;
  cell_ctrl_t             ctrl;
  logic                   accept;
  logic                   active;
  logic                   fire;
  logic                   stop_q, stop_d;
  logic                   s1_valid_q, s1_valid_d;
  item_t                  s1_item_q;

  // pattern registers, aligned to window places at write time
  pocnt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pat_o      (pat),
    .used_o     (used),
    .eff_len_o  (eff_len)
  );

  // a transfer is taken when the tally stage is empty or moves on
  assign in_ready_o = !s1_valid_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  // a byte counts only before the first zero byte of the text
  assign active = !stop_q && (text_byte_i != '0);

  always_comb begin
    ctrl.load  = accept;
    ctrl.shift = accept && active;
    ctrl.clear = accept && last_byte_i;
  end

  always_comb begin
    stop_d = stop_q;
    if (accept) begin
      if (last_byte_i) begin
        stop_d = 1'b0;
      end else if (!stop_q && (text_byte_i == '0)) begin
        stop_d = 1'b1;
      end
    end
    s1_valid_d = accept || (s1_valid_q && !fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      stop_q     <= stop_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= '{active: active, last: last_byte_i, len: eff_len};
    end
  end

  // window cells: cell 0 takes the new byte, each other cell its left neighbour
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign chain_in[k] = text_byte_i;
    end else begin : g_body
      assign chain_in[k] = win[k-1];
    end

    pocnt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .byte_i(chain_in[k]),
      .pat_i (pat[k]),
      .used_i(used[k]),
      .byte_o(win[k]),
      .ok_o  (ok[k])
    );
  end

  // cooldown, count and the output register
  pocnt_tally u_tally (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (s1_valid_q),
    .item_i            (s1_item_q),
    .ok_i              (ok),
    .fire_o            (fire),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .occurrence_count_o(occurrence_count_o),
    .count_saturated_o (count_saturated_o)
  );

endmodule
